[sv/ffa_pkg.sv]
package ffa_pkg;

    // Address and length width of the pool
    localparam int ADDR_BITS = 32;
    localparam logic [15:0] ADJ_MAX = 16'hffff;

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_NULL    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [31:0]          len;
    } t_fent;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          size;
        logic [15:0]          adj;
        logic [3:0]           lg;
    } t_aent;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FAIL,
        CMD_SLOT,
        CMD_FREAD,
        CMD_FEVAL,
        CMD_SHDN_RD,
        CMD_SHDN_WR,
        CMD_ACOMMIT,
        CMD_ARD,
        CMD_AEV,
        CMD_QRES,
        CMD_FSETUP,
        CMD_PEV,
        CMD_MBOTH,
        CMD_MPREV,
        CMD_MNEXT,
        CMD_INS,
        CMD_SHUP_RD,
        CMD_SHUP_WR,
        CMD_INS_PUT,
        CMD_RELEASE,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic       init_busy;
        logic [1:0] op;
        logic       req_zero;
        logic       alloc_full;
        logic       addr_null;
        logic       slot_free;
        logic       f_end;
        logic       fit;
        logic       whole;
        logic       dn_more;
        logic       rec_hit;
        logic       rec_last;
        logic       below;
        logic       mprev;
        logic       mnext;
        logic       free_full;
        logic       up_more;
        logic       out_free;
    } t_stat;

endpackage

[sv/ffa_ctrl.sv]
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SLOT, S_FRD, S_FEV, S_SHDN, S_SHDN_WR, S_ACOMMIT,
        S_ARD, S_AEV, S_QRES, S_FSETUP, S_PRD, S_PEV, S_MERGE, S_SHUP,
        S_SHUP_WR, S_RELEASE, S_DONE
    } t_state;

    t_state r_state, n_state;

    // Sequence the datapath one command per cycle, holding in S_DONE until the output is free
    always_comb begin
        n_state   = r_state;
        o_cmd     = '{op: CMD_NONE, code: ST_OK};
        o_s_ready = (r_state == S_IDLE) && !i_stat.init_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid && o_s_ready) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                priority if (i_stat.op == OP_ALLOC) begin
                    priority if (i_stat.req_zero) begin
                        o_cmd = '{op: CMD_FAIL, code: ST_UNKNOWN};
                    end else if (i_stat.alloc_full) begin
                        o_cmd = '{op: CMD_FAIL, code: ST_FULL};
                    end else begin
                        n_state = S_SLOT;
                    end
                end else if (i_stat.op == OP_FREE || i_stat.op == OP_QUERY) begin
                    if (i_stat.addr_null) begin
                        o_cmd = '{op: CMD_FAIL, code: ST_NULL};
                    end else begin
                        n_state = S_ARD;
                    end
                end else begin
                    o_cmd = '{op: CMD_FAIL, code: ST_UNKNOWN};
                end
            end
            S_SLOT: begin
                o_cmd.op = CMD_SLOT;
                if (i_stat.slot_free) n_state = S_FRD;
            end
            S_FRD: begin
                if (i_stat.f_end) begin
                    o_cmd   = '{op: CMD_FAIL, code: ST_NOFIT};
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = CMD_FREAD;
                    n_state  = S_FEV;
                end
            end
            S_FEV: begin
                o_cmd.op = CMD_FEVAL;
                priority if (i_stat.fit && i_stat.whole) n_state = S_SHDN;
                else if (i_stat.fit) n_state = S_ACOMMIT;
                else n_state = S_FRD;
            end
            S_SHDN: begin
                priority if (i_stat.dn_more) begin
                    o_cmd.op = CMD_SHDN_RD;
                    n_state  = S_SHDN_WR;
                end else if (i_stat.op == OP_ALLOC) begin
                    n_state = S_ACOMMIT;
                end else begin
                    n_state = S_RELEASE;
                end
            end
            S_SHDN_WR: begin
                o_cmd.op = CMD_SHDN_WR;
                n_state  = S_SHDN;
            end
            S_ACOMMIT: begin
                o_cmd.op = CMD_ACOMMIT;
                n_state  = S_DONE;
            end
            S_ARD: begin
                o_cmd.op = CMD_ARD;
                n_state  = S_AEV;
            end
            S_AEV: begin
                o_cmd.op = CMD_AEV;
                priority if (i_stat.rec_hit) begin
                    n_state = (i_stat.op == OP_QUERY) ? S_QRES : S_FSETUP;
                end else if (i_stat.rec_last) begin
                    o_cmd   = '{op: CMD_FAIL, code: ST_UNKNOWN};
                    n_state = S_DONE;
                end else begin
                    n_state = S_ARD;
                end
            end
            S_QRES: begin
                o_cmd.op = CMD_QRES;
                n_state  = S_DONE;
            end
            S_FSETUP: begin
                o_cmd.op = CMD_FSETUP;
                n_state  = S_PRD;
            end
            S_PRD: begin
                if (i_stat.f_end) begin
                    n_state = S_MERGE;
                end else begin
                    o_cmd.op = CMD_FREAD;
                    n_state  = S_PEV;
                end
            end
            S_PEV: begin
                o_cmd.op = CMD_PEV;
                n_state  = i_stat.below ? S_PRD : S_MERGE;
            end
            S_MERGE: begin
                priority if (i_stat.mprev && i_stat.mnext) begin
                    o_cmd.op = CMD_MBOTH;
                    n_state  = S_SHDN;
                end else if (i_stat.mprev) begin
                    o_cmd.op = CMD_MPREV;
                    n_state  = S_RELEASE;
                end else if (i_stat.mnext) begin
                    o_cmd.op = CMD_MNEXT;
                    n_state  = S_RELEASE;
                end else if (i_stat.free_full) begin
                    o_cmd   = '{op: CMD_FAIL, code: ST_FULL};
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = CMD_INS;
                    n_state  = S_SHUP;
                end
            end
            S_SHUP: begin
                if (i_stat.up_more) begin
                    o_cmd.op = CMD_SHUP_RD;
                    n_state  = S_SHUP_WR;
                end else begin
                    o_cmd.op = CMD_INS_PUT;
                    n_state  = S_RELEASE;
                end
            end
            S_SHUP_WR: begin
                o_cmd.op = CMD_SHUP_WR;
                n_state  = S_SHUP;
            end
            S_RELEASE: begin
                o_cmd.op = CMD_RELEASE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/ffa_dpath.sv]
module ffa_dpath
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES  = 64,
    parameter int ALLOC_ENTRIES = 64,
    parameter int HEADER_BYTES  = 16,
    parameter int LCW           = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_req,
    input  logic [3:0]           i_lg,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [ADDR_BITS-1:0] o_raddr,
    output logic [31:0]          o_rsize,
    output logic [15:0]          o_ralign,
    output logic [31:0]          o_used,
    output logic [LCW-1:0]       o_live
);

    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int AIW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int ACW = $clog2(ALLOC_ENTRIES + 1);
    localparam logic [17:0] HDR = 18'(HEADER_BYTES);

    // Memories
    t_fent r_fmem [FREE_ENTRIES];
    t_aent r_amem [ALLOC_ENTRIES];

    // Control state
    logic [31:0]              r_base, r_size;
    logic                     r_init;
    logic [FCW-1:0]           r_fcount;
    logic [ALLOC_ENTRIES-1:0] r_valid;
    logic [31:0]              r_used;
    logic [LCW-1:0]           r_acount;
    logic                     r_ovalid;

    // Work registers
    logic [1:0]           r_op;
    logic [31:0]          r_req;
    logic [3:0]           r_lg;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ACW-1:0]       r_ai;
    logic [AIW-1:0]       r_slot;
    logic [FCW-1:0]       r_f, r_sh;
    t_fent                r_frd, r_prev;
    t_aent                r_ard;
    logic                 r_ard_v;
    logic [ADDR_BITS-1:0] r_bblk, r_bstart, r_bend;
    logic [31:0]          r_bsize, r_take;
    logic [15:0]          r_adj;
    logic [2:0]           r_status;
    logic [ADDR_BITS-1:0] r_raddr;
    logic [31:0]          r_rsize;
    logic [15:0]          r_ralign;

    // Output register
    logic [2:0]           r_o_status;
    logic [ADDR_BITS-1:0] r_o_raddr;
    logic [31:0]          r_o_rsize;
    logic [15:0]          r_o_ralign;
    logic [31:0]          r_o_used;
    logic [LCW-1:0]       r_o_live;

    logic [AIW-1:0] w_ai_idx;
    assign w_ai_idx = r_ai[AIW-1:0];

    // Adjustment and fit of the entry just read
    logic [17:0] w_align, w_mask, w_adj0, w_need, w_adj;
    logic [32:0] w_total, w_rem;
    logic        w_fit, w_whole;
    always_comb begin
        w_align = 18'd1 << r_lg;
        w_mask  = w_align - 18'd1;
        w_adj0  = (~r_frd.start[17:0] + 18'd1) & w_mask;
        w_need  = HDR - w_adj0;
        w_adj   = (w_adj0 < HDR) ? w_adj0 + ((w_need + w_mask) & ~w_mask) : w_adj0;
        w_total = {1'b0, r_req} + 33'(w_adj);
        w_fit   = ({1'b0, r_frd.len} >= w_total) && (w_adj <= 18'(ADJ_MAX));
        w_rem   = {1'b0, r_frd.len} - w_total;
        w_whole = w_rem <= 33'(HEADER_BYTES);
    end

    // Neighbor tests for a free
    logic [ADDR_BITS-1:0] w_prev_end;
    logic                 w_mprev, w_mnext, w_rec_hit;
    always_comb begin
        w_prev_end = r_prev.start + r_prev.len;
        w_mprev    = (r_f != '0) && (w_prev_end == r_bstart);
        w_mnext    = (r_f < r_fcount) && (r_frd.start == r_bend);
        w_rec_hit  = r_ard_v && (r_ard.addr == r_addr);
    end

    // Status to the controller
    always_comb begin
        o_stat.init_busy  = r_init;
        o_stat.op         = r_op;
        o_stat.req_zero   = (r_req == '0);
        o_stat.alloc_full = (r_acount >= LCW'(ALLOC_ENTRIES));
        o_stat.addr_null  = (r_addr == '0);
        o_stat.slot_free  = !r_valid[w_ai_idx];
        o_stat.f_end      = (r_f == r_fcount);
        o_stat.fit        = w_fit;
        o_stat.whole      = w_whole;
        o_stat.dn_more    = (r_sh < r_fcount);
        o_stat.rec_hit    = w_rec_hit;
        o_stat.rec_last   = (r_ai == ACW'(ALLOC_ENTRIES - 1));
        o_stat.below      = (r_frd.start < r_bend);
        o_stat.mprev      = w_mprev;
        o_stat.mnext      = w_mnext;
        o_stat.free_full  = (r_fcount == FCW'(FREE_ENTRIES));
        o_stat.up_more    = (r_sh > r_f);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    // Free table port selection
    logic           w_fre, w_fwe;
    logic [FIW-1:0] w_fraddr, w_fwaddr;
    t_fent          w_fwdata;
    logic [FCW-1:0] w_fm1, w_shp1, w_shm1;
    always_comb begin
        w_fm1    = r_f - FCW'(1);
        w_shp1   = r_sh + FCW'(1);
        w_shm1   = r_sh - FCW'(1);
        w_fre    = 1'b0;
        w_fraddr = r_f[FIW-1:0];
        w_fwe    = 1'b0;
        w_fwaddr = r_f[FIW-1:0];
        w_fwdata = r_frd;
        priority if (i_cfg_we) begin
            w_fwe          = 1'b1;
            w_fwaddr       = '0;
            w_fwdata.start = (i_cfg_index == CFG_POOL_BASE) ? i_cfg_data : r_base;
            w_fwdata.len   = (i_cfg_index == CFG_POOL_BASE) ? r_size : i_cfg_data;
        end else if (r_init) begin
            w_fwe    = 1'b1;
            w_fwaddr = '0;
            w_fwdata = '{start: r_base, len: r_size};
        end else begin
            unique case (i_cmd.op)
                CMD_FREAD: w_fre = 1'b1;
                CMD_SHDN_RD: begin
                    w_fre    = 1'b1;
                    w_fraddr = w_shp1[FIW-1:0];
                end
                CMD_SHUP_RD: begin
                    w_fre    = 1'b1;
                    w_fraddr = w_shm1[FIW-1:0];
                end
                CMD_FEVAL: begin
                    w_fwe    = w_fit && !w_whole;
                    w_fwdata = '{start: r_frd.start + w_total[31:0],
                                 len:   r_frd.len - w_total[31:0]};
                end
                CMD_SHDN_WR, CMD_SHUP_WR: begin
                    w_fwe    = 1'b1;
                    w_fwaddr = r_sh[FIW-1:0];
                end
                CMD_MBOTH: begin
                    w_fwe    = 1'b1;
                    w_fwaddr = w_fm1[FIW-1:0];
                    w_fwdata = '{start: r_prev.start,
                                 len:   r_prev.len + r_bsize + r_frd.len};
                end
                CMD_MPREV: begin
                    w_fwe    = 1'b1;
                    w_fwaddr = w_fm1[FIW-1:0];
                    w_fwdata = '{start: r_prev.start, len: r_prev.len + r_bsize};
                end
                CMD_MNEXT: begin
                    w_fwe    = 1'b1;
                    w_fwdata = '{start: r_bstart, len: r_frd.len + r_bsize};
                end
                CMD_INS_PUT: begin
                    w_fwe    = 1'b1;
                    w_fwdata = '{start: r_bstart, len: r_bsize};
                end
                default: w_fwe = 1'b0;
            endcase
        end
    end

    // Free table memory
    always_ff @(posedge i_clk) begin
        if (w_fwe) r_fmem[w_fwaddr] <= w_fwdata;
        if (w_fre) r_frd <= r_fmem[w_fraddr];
    end

    // Allocation record memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_ACOMMIT) begin
            r_amem[r_slot] <= '{addr: r_bblk + ADDR_BITS'(r_adj), size: r_take,
                                adj: r_adj, lg: r_lg};
        end
        if (i_cmd.op == CMD_ARD) r_ard <= r_amem[w_ai_idx];
    end

    // Control state: pool, counts, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_size   <= 32'd65536;
            r_init   <= 1'b1;
            r_fcount <= FCW'(1);
            r_valid  <= '0;
            r_used   <= '0;
            r_acount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_init <= 1'b0;
            if (i_out_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_POOL_BASE) r_base <= i_cfg_data;
                else r_size <= i_cfg_data;
                r_fcount <= FCW'(1);
                r_valid  <= '0;
                r_used   <= '0;
                r_acount <= '0;
            end else begin
                unique case (i_cmd.op)
                    CMD_FEVAL: if (w_fit && w_whole) r_fcount <= r_fcount - FCW'(1);
                    CMD_MBOTH: r_fcount <= r_fcount - FCW'(1);
                    CMD_INS_PUT: r_fcount <= r_fcount + FCW'(1);
                    CMD_ACOMMIT: begin
                        r_valid[r_slot] <= 1'b1;
                        r_used          <= r_used + r_take;
                        r_acount        <= r_acount + LCW'(1);
                    end
                    CMD_RELEASE: begin
                        r_valid[w_ai_idx] <= 1'b0;
                        r_used            <= r_used - r_bsize;
                        r_acount          <= r_acount - LCW'(1);
                    end
                    CMD_EMIT: r_ovalid <= 1'b1;
                    default: r_fcount <= r_fcount;
                endcase
            end
        end
    end

    // Work and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_op     <= i_op;
                r_req    <= i_req;
                r_lg     <= i_lg;
                r_addr   <= i_addr;
                r_ai     <= '0;
                r_f      <= '0;
                r_status <= ST_OK;
                r_raddr  <= '0;
                r_rsize  <= '0;
                r_ralign <= '0;
            end
            CMD_FAIL: r_status <= i_cmd.code;
            CMD_SLOT: begin
                if (!r_valid[w_ai_idx]) r_slot <= w_ai_idx;
                else r_ai <= r_ai + ACW'(1);
            end
            CMD_FEVAL: begin
                if (w_fit) begin
                    r_bblk <= r_frd.start;
                    r_adj  <= w_adj[15:0];
                    r_sh   <= r_f;
                    r_take <= w_whole ? r_frd.len : w_total[31:0];
                end else begin
                    r_f <= r_f + FCW'(1);
                end
            end
            CMD_SHDN_WR: r_sh <= r_sh + FCW'(1);
            CMD_SHUP_WR: r_sh <= r_sh - FCW'(1);
            CMD_ACOMMIT: begin
                r_raddr <= r_bblk + ADDR_BITS'(r_adj);
                r_rsize <= r_take;
            end
            CMD_ARD: r_ard_v <= r_valid[w_ai_idx];
            CMD_AEV: if (!w_rec_hit) r_ai <= r_ai + ACW'(1);
            CMD_QRES: begin
                r_rsize  <= r_ard.size - 32'(r_ard.adj);
                r_ralign <= 16'd1 << r_ard.lg;
            end
            CMD_FSETUP: begin
                r_bstart <= r_addr - ADDR_BITS'(r_ard.adj);
                r_bend   <= r_addr - ADDR_BITS'(r_ard.adj) + r_ard.size;
                r_bsize  <= r_ard.size;
                r_f      <= '0;
            end
            CMD_PEV: begin
                if (r_frd.start < r_bend) begin
                    r_prev <= r_frd;
                    r_f    <= r_f + FCW'(1);
                end
            end
            CMD_MBOTH: r_sh <= r_f;
            CMD_INS: r_sh <= r_fcount;
            CMD_EMIT: begin
                r_o_status <= r_status;
                r_o_raddr  <= r_raddr;
                r_o_rsize  <= r_rsize;
                r_o_ralign <= r_ralign;
                r_o_used   <= r_used;
                r_o_live   <= r_acount;
            end
            default: r_f <= r_f;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_o_status;
    assign o_raddr     = r_o_raddr;
    assign o_rsize     = r_o_rsize;
    assign o_ralign    = r_o_ralign;
    assign o_used      = r_o_used;
    assign o_live      = r_o_live;

endmodule

[sv/first_fit_free_list_allocator.sv]
// Allocate scans the record slots for a free record, walks the free entries for a fit and
// shifts the free entries down on a whole-block take. Free and query search the records;
// free then walks the free list and shifts entries to merge or insert the block.
// One item at a time through one port of each table.
// Synchronous active-low reset; the cycle after reset loads the single pool entry and no
// item is accepted in that cycle; a config write loads it in the write cycle itself.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES  = 64,
    parameter int ALLOC_ENTRIES = 64,
    parameter int HEADER_BYTES  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // request_size[31:0], alignment_log2[35:32], address[67:36], zero pad
    input  logic [71:0]       s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result_address[31:0], result_size[63:32], result_alignment[79:64],
    // used_bytes[111:80], live_allocations[112+], zero pad
    output logic [((112 + $clog2(ALLOC_ENTRIES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]        m_axis_tuser
);

    localparam int LCW      = $clog2(ALLOC_ENTRIES + 1);
    localparam int OUT_BITS = 112 + LCW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    t_cmd                 w_cmd;
    t_stat                w_stat;
    logic [ADDR_BITS-1:0] w_raddr;
    logic [31:0]          w_rsize, w_used;
    logic [15:0]          w_ralign;
    logic [LCW-1:0]       w_live;

    ffa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ffa_dpath #(
        .FREE_ENTRIES  (FREE_ENTRIES),
        .ALLOC_ENTRIES (ALLOC_ENTRIES),
        .HEADER_BYTES  (HEADER_BYTES),
        .LCW           (LCW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_req       (s_axis_tdata[31:0]),
        .i_lg        (s_axis_tdata[35:32]),
        .i_addr      (s_axis_tdata[67:36]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_raddr     (w_raddr),
        .o_rsize     (w_rsize),
        .o_ralign    (w_ralign),
        .o_used      (w_used),
        .o_live      (w_live)
    );

    // Pack the result fields
    always_comb begin
        m_axis_tdata                  = '0;
        m_axis_tdata[31:0]            = w_raddr;
        m_axis_tdata[63:32]           = w_rsize;
        m_axis_tdata[79:64]           = w_ralign;
        m_axis_tdata[111:80]          = w_used;
        m_axis_tdata[112 +: LCW]      = w_live;
    end

endmodule

[sv/ffa_checker.sv]
module ffa_checker
    import ffa_pkg::*;
#(
    parameter int ALLOC_ENTRIES = 64,
    parameter int OUT_W         = 120
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [2:0]       m_axis_tuser
);

    localparam int LCW = $clog2(ALLOC_ENTRIES + 1);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // One item at a time: a transfer in closes the input side
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // A failed item returns no address, size or alignment
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[79:0] == '0)
        else $error("failed item carries a result");

    // Live count never exceeds the record table
    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[112 +: LCW] <= LCW'(ALLOC_ENTRIES))
        else $error("live count out of range");

endmodule

bind first_fit_free_list_allocator ffa_checker #(
    .ALLOC_ENTRIES (ALLOC_ENTRIES),
    .OUT_W         (OUT_W)
) u_ffa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
